// ===== rtl/halfword_alu_with_condition_code_macros.svh =====
// Assertion macros for the halfword ALU; clocked on clk_i, disabled during reset.
`ifndef HALFWORD_ALU_WITH_CONDITION_CODE_MACROS_SVH
`define HALFWORD_ALU_WITH_CONDITION_CODE_MACROS_SVH

// Same-cycle implication.
`define HWALU_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define HWALU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/hwalu_pkg.sv =====
// Shared types and constants of the halfword ALU.
`default_nettype none

package hwalu_pkg;

  localparam int unsigned HALF_W      = 16;
  localparam int unsigned REG_IDX_W   = 4;
  localparam int unsigned DISP_W      = 12;
  localparam int unsigned HOST_IDX_W  = 13;
  localparam int unsigned EA_OUT_W    = 14;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_AR   = 3'd0,
    KIND_SR   = 3'd1,
    KIND_LH   = 3'd2,
    KIND_AH   = 3'd3,
    KIND_SH   = 3'd4,
    KIND_CH   = 3'd5,
    KIND_STH  = 3'd6,
    KIND_HOST = 3'd7
  } kind_e;

  localparam logic [1:0] CC_ZERO = 2'd0;
  localparam logic [1:0] CC_NEG  = 2'd1;
  localparam logic [1:0] CC_POS  = 2'd2;
  localparam logic [1:0] CC_OVF  = 2'd3;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ODD  = 2'd1;
  localparam logic [1:0] FAULT_NEG  = 2'd2;

  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    half_t                data;
  } reg_wr_t;

  typedef struct packed {
    half_t      sum;
    logic [1:0] cc;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/hwalu_alu.sv =====
// 16-bit add/subtract with condition code for arithmetic and compare kinds.
`default_nettype none

module hwalu_alu (
  input  hwalu_pkg::kind_e    kind_i,
  input  hwalu_pkg::half_t    a_i,
  input  hwalu_pkg::half_t    b_i,
  output hwalu_pkg::alu_res_t res_o
);
  import hwalu_pkg::*;

  logic        sub;
  logic [16:0] ax;
  logic [16:0] bx;
  logic [16:0] r;
  logic        ovf;

  always_comb begin
    sub = kind_i inside {KIND_SR, KIND_SH, KIND_CH};
    ax  = {a_i[HALF_W-1], a_i};
    bx  = {b_i[HALF_W-1], b_i};
    r   = sub ? (ax - bx) : (ax + bx);
    ovf = r[16] ^ r[15];
    res_o.sum = r[HALF_W-1:0];
    if (kind_i == KIND_CH) begin
      // 17-bit difference is exact, so its sign gives the ordering
      if (r == '0) begin
        res_o.cc = CC_ZERO;
      end else if (r[16]) begin
        res_o.cc = CC_NEG;
      end else begin
        res_o.cc = CC_POS;
      end
    end else if (ovf) begin
      res_o.cc = CC_OVF;
    end else if (r[HALF_W-1:0] == '0) begin
      res_o.cc = CC_ZERO;
    end else if (r[15]) begin
      res_o.cc = CC_NEG;
    end else begin
      res_o.cc = CC_POS;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hwalu_regfile.sv =====
// General register file: synchronous two-read one-write memory with per-entry valid bits.
`default_nettype none

module hwalu_regfile #(
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [hwalu_pkg::REG_IDX_W-1:0] rd_a_idx_i,
  input  logic [hwalu_pkg::REG_IDX_W-1:0] rd_b_idx_i,
  output hwalu_pkg::half_t                rd_a_data_o,
  output hwalu_pkg::half_t                rd_b_data_o,
  input  hwalu_pkg::reg_wr_t              wr_i
);
  import hwalu_pkg::*;

  localparam int unsigned RIW = $clog2(REGISTER_COUNT);
  localparam logic [REG_IDX_W:0] COUNT_L = (REG_IDX_W + 1)'(REGISTER_COUNT);

  half_t                     mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_q;
  half_t                     a_data_q;
  half_t                     b_data_q;
  logic                      a_ok_q;
  logic                      b_ok_q;
  logic                      wr_ok;
  logic                      a_hit;
  logic                      b_hit;
  logic                      a_range;
  logic                      b_range;

  assign wr_ok   = wr_i.en && ({1'b0, wr_i.idx} < COUNT_L);
  assign a_range = {1'b0, rd_a_idx_i} < COUNT_L;
  assign b_range = {1'b0, rd_b_idx_i} < COUNT_L;
  // write-first bypass for a read at the edge of a write
  assign a_hit   = wr_ok && (wr_i.idx == rd_a_idx_i);
  assign b_hit   = wr_ok && (wr_i.idx == rd_b_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_i.idx[RIW-1:0]] <= wr_i.data;
    end
    if (rd_en_i) begin
      a_data_q <= a_hit ? wr_i.data : mem[rd_a_idx_i[RIW-1:0]];
      b_data_q <= b_hit ? wr_i.data : mem[rd_b_idx_i[RIW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      a_ok_q  <= 1'b0;
      b_ok_q  <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid_q[wr_i.idx[RIW-1:0]] <= 1'b1;
      end
      if (rd_en_i) begin
        a_ok_q <= a_range && (a_hit || valid_q[rd_a_idx_i[RIW-1:0]]);
        b_ok_q <= b_range && (b_hit || valid_q[rd_b_idx_i[RIW-1:0]]);
      end
    end
  end

  // never-written and nonexistent registers read as zero
  assign rd_a_data_o = a_ok_q ? a_data_q : '0;
  assign rd_b_data_o = b_ok_q ? b_data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/hwalu_store.sv =====
// Main store: synchronous halfword memory with a clearing pass after reset.
`default_nettype none

module hwalu_store #(
  parameter int unsigned ADDRESS_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [ADDRESS_BITS-2:0] rd_idx_i,
  output hwalu_pkg::half_t        rd_data_o,
  input  logic                    wr_en_i,
  input  logic [ADDRESS_BITS-2:0] wr_idx_i,
  input  hwalu_pkg::half_t        wr_data_i,
  output logic                    busy_o
);
  import hwalu_pkg::*;

  localparam int unsigned SIW   = ADDRESS_BITS - 1;
  localparam int unsigned DEPTH = 1 << SIW;

  half_t          mem [DEPTH];
  half_t          rd_q;
  logic           clr_q;
  logic [SIW-1:0] clr_idx_q;
  logic           we;
  logic [SIW-1:0] wa;
  half_t          wd;

  assign we = clr_q || wr_en_i;
  assign wa = clr_q ? clr_idx_q : wr_idx_i;
  assign wd = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= (we && (wa == rd_idx_i)) ? wd : mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + SIW'(1);
      if (&clr_idx_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_q;

endmodule

`default_nettype wire

// ===== rtl/halfword_alu_with_condition_code.sv =====
// Halfword ALU with condition code: pipeline, hazard interlock and stream ports.
//
// One instruction per input transfer: tuser carries the kind (AR, SR, LH, AH, SH, CH,
// STH or host store write), tdata the register numbers, base, displacement and host
// index/data. Each instruction yields exactly one output transfer with R1 (or the
// stored halfword), the condition code, fault, byte address and a stored flag.
//
// Pipeline: accept cycle reads the register file, stage 1 forms the address and reads
// the store, stage 2 runs the ALU and writes back, then an output register. One
// instruction per cycle is accepted while no hazard, store clear or output stall holds
// input. An address-forming instruction whose base register is the destination of one
// of the two instructions ahead waits for that write, and longer while the output is
// stalled.
//
// After reset the store is swept to zero, one halfword per cycle, all 2^(ADDRESS_BITS-1)
// halfwords (8192 at the default); s_axis_tready stays low meanwhile. Registers read as
// zero until written and the condition code resets to zero. When the output is
// stalled the pipeline holds and input is taken until all stages are full.
`default_nettype none
`include "halfword_alu_with_condition_code_macros.svh"

module halfword_alu_with_condition_code #(
  parameter int unsigned ADDRESS_BITS   = 14,
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // first_register, second_register, base_field, displacement, host_index, host_data
  input  logic [hwalu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [hwalu_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // register_result, condition_code, fault, byte_address, stored
  output logic [hwalu_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hwalu_pkg::*;

  localparam int unsigned SIW = ADDRESS_BITS - 1;
  localparam logic [REG_IDX_W:0] COUNT_L = (REG_IDX_W + 1)'(REGISTER_COUNT);

  function automatic logic is_rs(kind_e k);
    return k inside {KIND_LH, KIND_AH, KIND_SH, KIND_CH, KIND_STH};
  endfunction

  function automatic logic is_rr(kind_e k);
    return k inside {KIND_AR, KIND_SR};
  endfunction

  function automatic logic writes_reg(kind_e k);
    return k inside {KIND_AR, KIND_SR, KIND_LH, KIND_AH, KIND_SH};
  endfunction

  // input unpacking
  kind_e                 in_kind;
  logic [REG_IDX_W-1:0]  in_r1;
  logic [REG_IDX_W-1:0]  in_r2;
  logic [REG_IDX_W-1:0]  in_b2;
  logic [DISP_W-1:0]     in_d2;
  logic [HOST_IDX_W-1:0] in_hidx;
  half_t                 in_hdata;
  logic                  accept;
  logic                  hazard;

  assign in_kind  = kind_e'(s_axis_tuser);
  assign in_r1    = s_axis_tdata[3:0];
  assign in_r2    = s_axis_tdata[7:4];
  assign in_b2    = s_axis_tdata[11:8];
  assign in_d2    = s_axis_tdata[23:12];
  assign in_hidx  = s_axis_tdata[36:24];
  assign in_hdata = s_axis_tdata[52:37];

  // stage registers
  logic                  s1_valid_q;
  kind_e                 s1_kind_q;
  logic [REG_IDX_W-1:0]  s1_r1_q;
  logic [REG_IDX_W-1:0]  s1_rb_q;
  logic [REG_IDX_W-1:0]  s1_b2_q;
  logic [DISP_W-1:0]     s1_d2_q;
  logic [HOST_IDX_W-1:0] s1_hidx_q;
  half_t                 s1_hdata_q;

  logic                  s2_valid_q;
  kind_e                 s2_kind_q;
  logic [REG_IDX_W-1:0]  s2_r1_q;
  half_t                 s2_v1_q;
  half_t                 s2_v2_q;
  logic [ADDRESS_BITS-1:0] s2_ea_q;
  logic [1:0]            s2_fault_q;
  logic [HOST_IDX_W-1:0] s2_hidx_q;
  half_t                 s2_hdata_q;

  logic                  out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [1:0]            cc_q;

  logic                  s1_adv;
  logic                  s2_adv;
  logic                  st_busy;

  assign s2_adv = s2_valid_q && (!out_valid_q || m_axis_tready);
  assign s1_adv = s1_valid_q && (!s2_valid_q || s2_adv);

  // base register must not be pending in either stage
  assign hazard = is_rs(in_kind) && in_b2[REG_IDX_W-1] &&
                  ((s1_valid_q && writes_reg(s1_kind_q) && (s1_r1_q == in_b2)) ||
                   (s2_valid_q && writes_reg(s2_kind_q) && (s2_r1_q == in_b2)));

  assign s_axis_tready = !st_busy && !hazard && (!s1_valid_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // register file
  half_t                rf_a;
  half_t                rf_b;
  reg_wr_t              rf_wr;
  logic [REG_IDX_W-1:0] rf_b_idx;

  assign rf_b_idx = is_rr(in_kind) ? in_r2 : in_b2;

  hwalu_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_a_idx_i (in_r1),
    .rd_b_idx_i (rf_b_idx),
    .rd_a_data_o(rf_a),
    .rd_b_data_o(rf_b),
    .wr_i       (rf_wr)
  );

  // stage 1: effective address
  logic [16:0]             base_sum;
  logic [EA_OUT_W-1:0]     direct_ea;
  logic [16:0]             ea_wide;
  logic [ADDRESS_BITS-1:0] s1_ea;
  logic                    s1_neg;
  logic [1:0]              s1_fault;
  logic [ADDRESS_BITS-1:0] s1_ea_out;
  half_t                   s1_v1_fwd;
  half_t                   s1_v2_fwd;

  always_comb begin
    base_sum  = {rf_b[HALF_W-1], rf_b} + {5'b0, s1_d2_q};
    direct_ea = {s1_b2_q[1:0], s1_d2_q};
    ea_wide   = s1_b2_q[REG_IDX_W-1] ? base_sum : {3'b0, direct_ea};
    s1_ea     = ea_wide[ADDRESS_BITS-1:0];
    s1_neg    = s1_b2_q[REG_IDX_W-1] && base_sum[16];
    if (!is_rs(s1_kind_q)) begin
      s1_fault  = FAULT_NONE;
      s1_ea_out = '0;
    end else if (s1_neg) begin
      s1_fault  = FAULT_NEG;
      s1_ea_out = '0;
    end else begin
      s1_fault  = s1_ea[0] ? FAULT_ODD : FAULT_NONE;
      s1_ea_out = s1_ea;
    end
    // the instruction ahead writes back at the edge this one moves on
    s1_v1_fwd = (rf_wr.en && (rf_wr.idx == s1_r1_q)) ? rf_wr.data : rf_a;
    s1_v2_fwd = (rf_wr.en && (rf_wr.idx == s1_rb_q)) ? rf_wr.data : rf_b;
  end

  // main store
  half_t          st_rd_data;
  logic           st_we;
  logic [SIW-1:0] st_widx;
  half_t          st_wdata;

  hwalu_store #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (s1_adv),
    .rd_idx_i (s1_ea[ADDRESS_BITS-1:1]),
    .rd_data_o(st_rd_data),
    .wr_en_i  (st_we),
    .wr_idx_i (st_widx),
    .wr_data_i(st_wdata),
    .busy_o   (st_busy)
  );

  // stage 2: execute and write back
  alu_res_t           alu_res;
  half_t              alu_b;
  logic               s2_ok;
  logic               s2_r1_in;
  half_t              shown;
  logic [1:0]         cc_d;
  logic               stored;
  logic               rf_we;
  half_t              rf_wd;
  logic               st_we_raw;
  logic [15:0]        ea16;
  logic [15:0]        hidx16;

  assign alu_b = is_rr(s2_kind_q) ? s2_v2_q : st_rd_data;

  hwalu_alu u_alu (
    .kind_i(s2_kind_q),
    .a_i   (s2_v1_q),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  always_comb begin
    s2_ok     = s2_fault_q == FAULT_NONE;
    s2_r1_in  = {1'b0, s2_r1_q} < COUNT_L;
    shown     = s2_v1_q;
    cc_d      = cc_q;
    stored    = 1'b0;
    rf_we     = 1'b0;
    rf_wd     = alu_res.sum;
    st_we_raw = 1'b0;
    st_wdata  = s2_v1_q;
    ea16      = 16'(s2_ea_q);
    hidx16    = 16'(s2_hidx_q);
    st_widx   = s2_ea_q[ADDRESS_BITS-1:1];
    case (s2_kind_q)
      KIND_AR, KIND_SR: begin
        shown = alu_res.sum;
        cc_d  = alu_res.cc;
        rf_we = s2_r1_in;
      end
      KIND_LH: begin
        if (s2_ok) begin
          rf_we = s2_r1_in;
          rf_wd = st_rd_data;
          shown = s2_r1_in ? st_rd_data : '0;
        end
      end
      KIND_AH, KIND_SH: begin
        if (s2_ok) begin
          shown = alu_res.sum;
          cc_d  = alu_res.cc;
          rf_we = s2_r1_in;
        end
      end
      KIND_CH: begin
        if (s2_ok) begin
          cc_d = alu_res.cc;
        end
      end
      KIND_STH: begin
        if (s2_ok) begin
          st_we_raw = 1'b1;
          stored    = 1'b1;
        end
      end
      KIND_HOST: begin
        st_we_raw = 1'b1;
        stored    = 1'b1;
        st_wdata  = s2_hdata_q;
        st_widx   = hidx16[SIW-1:0];
        shown     = s2_hdata_q;
      end
      default: begin
        shown = s2_v1_q;
      end
    endcase
    rf_wr.en   = rf_we && s2_adv;
    rf_wr.idx  = s2_r1_q;
    rf_wr.data = rf_wd;
    st_we      = st_we_raw && s2_adv;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= in_kind;
      s1_r1_q    <= in_r1;
      s1_rb_q    <= rf_b_idx;
      s1_b2_q    <= in_b2;
      s1_d2_q    <= in_d2;
      s1_hidx_q  <= in_hidx;
      s1_hdata_q <= in_hdata;
    end
    if (s1_adv) begin
      s2_kind_q  <= s1_kind_q;
      s2_r1_q    <= s1_r1_q;
      s2_v1_q    <= s1_v1_fwd;
      s2_v2_q    <= s1_v2_fwd;
      s2_ea_q    <= s1_ea_out;
      s2_fault_q <= s1_fault;
      s2_hidx_q  <= s1_hidx_q;
      s2_hdata_q <= s1_hdata_q;
    end
    if (s2_adv) begin
      out_data_q <= {5'b0, stored, ea16[EA_OUT_W-1:0], s2_fault_q, cc_d, shown};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cc_q        <= CC_ZERO;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_q <= 1'b1;
        cc_q        <= cc_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `HWALU_ASSERT(a_clear_pipe_empty, st_busy, !s1_valid_q && !s2_valid_q, "work in flight during store clear")
  `HWALU_ASSERT(a_store_no_fault, st_we, s2_fault_q == FAULT_NONE, "store written by faulting instruction")
  `HWALU_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_r1_q), "stage 1 lost its instruction")

endmodule

`default_nettype wire

// ===== sim/halfword_alu_with_condition_code_checker.sv =====
// Scoreboard for the halfword ALU: tracks its state, predicts every result and compares.
`default_nettype none

module halfword_alu_with_condition_code_checker #(
  parameter int unsigned ADDRESS_BITS   = 14,
  parameter int unsigned REGISTER_COUNT = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [hwalu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [hwalu_pkg::KIND_W-1:0]      s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [hwalu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned                       failures_o,
  output int unsigned                       outstanding_o
);
  import hwalu_pkg::*;

  localparam int unsigned STORE_DEPTH = 1 << (ADDRESS_BITS - 1);
  localparam int unsigned ADDR_MASK   = (1 << ADDRESS_BITS) - 1;

  typedef struct packed {
    half_t               value;
    logic [1:0]          cc;
    logic [1:0]          flt;
    logic [EA_OUT_W-1:0] ea;
    logic                stored;
  } outcome_t;

  half_t      gpr       [REGISTER_COUNT];
  half_t      store_mem [STORE_DEPTH];
  logic [1:0] cc_state;
  outcome_t   pending_outcomes [$];

  initial begin
    for (int i = 0; i < REGISTER_COUNT; i++) gpr[i] = '0;
    for (int i = 0; i < STORE_DEPTH; i++) store_mem[i] = '0;
    cc_state      = CC_ZERO;
    failures_o    = 0;
    outstanding_o = 0;
  end

  function automatic half_t gpr_read(logic [REG_IDX_W-1:0] n);
    return (n < REGISTER_COUNT) ? gpr[n] : '0;
  endfunction

  function automatic void gpr_write(logic [REG_IDX_W-1:0] n, half_t v);
    if (n < REGISTER_COUNT) gpr[n] = v;
  endfunction

  // code for a widened signed sum landing in a 16-bit register
  function automatic logic [1:0] arith_code(int r);
    if (r > 32767 || r < -32768) return CC_OVF;
    if (r == 0) return CC_ZERO;
    return (r < 0) ? CC_NEG : CC_POS;
  endfunction

  function automatic outcome_t execute_instr(logic [KIND_W-1:0] kind,
                                             logic [IN_TDATA_W-1:0] fields);
    logic [3:0]  r1, r2, b2;
    logic [11:0] d2;
    logic [12:0] hidx;
    half_t       hdata, v1, mem;
    int          a, b, r, sum;
    int unsigned idx;
    int unsigned ea_full;
    outcome_t    res;
    r1      = fields[3:0];
    r2      = fields[7:4];
    b2      = fields[11:8];
    d2      = fields[23:12];
    hidx    = fields[36:24];
    hdata   = fields[52:37];
    v1      = gpr_read(r1);
    ea_full = 0;
    res     = '{value: v1, cc: CC_ZERO, flt: FAULT_NONE, ea: '0, stored: 1'b0};
    case (kind_e'(kind))
      KIND_HOST: begin
        store_mem[hidx % STORE_DEPTH] = hdata;
        res.value  = hdata;
        res.stored = 1'b1;
      end
      KIND_AR, KIND_SR: begin
        a = int'($signed(v1));
        b = int'($signed(gpr_read(r2)));
        r = (kind_e'(kind) == KIND_AR) ? a + b : a - b;
        res.value = half_t'(r);
        gpr_write(r1, res.value);
        cc_state = arith_code(r);
      end
      default: begin
        if (b2[3]) begin
          sum = int'($signed(gpr_read(b2))) + int'(d2);
          if (sum < 0) res.flt = FAULT_NEG;
          else ea_full = $unsigned(sum) & ADDR_MASK;
        end else begin
          // low two bits of B2 extend the displacement
          ea_full = 32'({b2[1:0], d2}) & ADDR_MASK;
        end
        res.ea = EA_OUT_W'(ea_full);
        if (res.flt == FAULT_NONE && ea_full[0]) res.flt = FAULT_ODD;
        if (res.flt == FAULT_NONE) begin
          idx = (ea_full >> 1) % STORE_DEPTH;
          mem = store_mem[idx];
          a   = int'($signed(v1));
          b   = int'($signed(mem));
          case (kind_e'(kind))
            KIND_LH: begin
              gpr_write(r1, mem);
              res.value = gpr_read(r1);
            end
            KIND_AH, KIND_SH: begin
              r = (kind_e'(kind) == KIND_AH) ? a + b : a - b;
              res.value = half_t'(r);
              gpr_write(r1, res.value);
              cc_state = arith_code(r);
            end
            KIND_CH: cc_state = (a == b) ? CC_ZERO : ((a < b) ? CC_NEG : CC_POS);
            default: begin
              store_mem[idx] = v1;
              res.stored     = 1'b1;
            end
          endcase
        end
      end
    endcase
    res.cc = cc_state;
    return res;
  endfunction

  task automatic check_result(logic [OUT_TDATA_W-1:0] data);
    outcome_t want, got;
    got.value  = data[15:0];
    got.cc     = data[17:16];
    got.flt    = data[19:18];
    got.ea     = data[33:20];
    got.stored = data[34];
    if (pending_outcomes.size() == 0) begin
      if (failures_o < 10)
        $display("%0t: result with nothing outstanding: r1=%h cc=%0d fault=%0d ea=%h st=%0b",
                 $realtime, got.value, got.cc, got.flt, got.ea, got.stored);
      failures_o++;
      return;
    end
    want = pending_outcomes.pop_front();
    if (got.value !== want.value || got.cc !== want.cc || got.flt !== want.flt ||
        got.ea !== want.ea || got.stored !== want.stored) begin
      if (failures_o < 10)
        $display("%0t: mismatch got r1=%h cc=%0d fault=%0d ea=%h st=%0b, want r1=%h cc=%0d fault=%0d ea=%h st=%0b",
                 $realtime, got.value, got.cc, got.flt, got.ea, got.stored,
                 want.value, want.cc, want.flt, want.ea, want.stored);
      failures_o++;
    end
  endtask

  // results leave before new instructions are predicted in the same cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        pending_outcomes.push_back(execute_instr(s_axis_tuser, s_axis_tdata));
      outstanding_o <= pending_outcomes.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/halfword_alu_with_condition_code_test.sv =====
// Testbench top for the halfword ALU: clock, reset, instruction stream and verdict.
`default_nettype none

module halfword_alu_with_condition_code_test;
  import hwalu_pkg::*;

  localparam int unsigned ADDR_BITS    = 14;
  localparam int unsigned REG_COUNT    = 16;
  localparam int unsigned RANDOM_ITEMS = 1830;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int unsigned            failures;
  int unsigned            outstanding;
  bit                     sender_burst;
  bit                     receiver_burst;

  halfword_alu_with_condition_code #(
    .ADDRESS_BITS  (ADDR_BITS),
    .REGISTER_COUNT(REG_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  halfword_alu_with_condition_code_checker #(
    .ADDRESS_BITS  (ADDR_BITS),
    .REGISTER_COUNT(REG_COUNT)
  ) alu_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .failures_o   (failures),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout covering the reset sweep of the store and the rest of the run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stall before each transfer unless in a burst stretch
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_instr(kind_e k, logic [3:0] r1, logic [3:0] r2, logic [3:0] b2,
                            logic [11:0] d2, logic [12:0] hidx, half_t hdata);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {3'b000, hdata, hidx, d2, b2, r2, r1};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic host_write(logic [12:0] hidx, half_t hdata);
    send_instr(KIND_HOST, 4'd0, 4'd0, 4'd0, 12'd0, hidx, hdata);
  endtask

  task automatic reg_op(kind_e k, logic [3:0] r1, logic [3:0] r2);
    send_instr(k, r1, r2, 4'd0, 12'd0, 13'd0, 16'd0);
  endtask

  task automatic storage_op(kind_e k, logic [3:0] r1, logic [3:0] b2, logic [11:0] d2);
    send_instr(k, r1, 4'd0, b2, d2, 13'd0, 16'd0);
  endtask

  // hold off new instructions until every outstanding result is out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic send_random();
    kind_e       k;
    logic [3:0]  r1, r2, b2;
    logic [11:0] d2;
    logic [12:0] hidx;
    half_t       hdata;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) k = KIND_HOST;
    else if (pick < 25) k = KIND_AR;
    else if (pick < 35) k = KIND_SR;
    else if (pick < 50) k = KIND_LH;
    else if (pick < 62) k = KIND_AH;
    else if (pick < 74) k = KIND_SH;
    else if (pick < 84) k = KIND_CH;
    else k = KIND_STH;
    r1    = 4'($urandom_range(0, 15));
    r2    = 4'($urandom_range(0, 15));
    b2    = 4'($urandom_range(0, 15));
    d2    = 12'($urandom_range(0, 4095));
    hidx  = 13'($urandom_range(0, 8191));
    hdata = half_t'($urandom_range(0, 65535));
    pick  = $urandom_range(0, 99);
    if (pick < 45) begin
      // small window shared by host writes and loads so data actually flows
      b2   = 4'($urandom_range(0, 1) * 4);
      d2   = 12'($urandom_range(0, 31) * 2);
      hidx = 13'($urandom_range(0, 31));
      if ($urandom_range(0, 1) == 1) hdata = half_t'($urandom_range(0, 1023) * 2);
    end else if (pick < 60) begin
      d2[0] = 1'b0;
    end else if (pick < 90) begin
      b2[3] = 1'b0;
      d2[0] = 1'b0;
    end
    send_instr(k, r1, r2, b2, d2, hidx, hdata);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_AR;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    host_write(13'd0, 16'h7FFF);
    host_write(13'd1, 16'h8000);
    host_write(13'd2, 16'h0001);
    host_write(13'h1FFF, 16'hFFFF);
    storage_op(KIND_LH, 4'd1, 4'd0, 12'd0);
    storage_op(KIND_LH, 4'd2, 4'd0, 12'd2);
    storage_op(KIND_LH, 4'd3, 4'd0, 12'd4);
    reg_op(KIND_AR, 4'd1, 4'd3);               // positive overflow
    reg_op(KIND_SR, 4'd2, 4'd3);               // negative overflow
    reg_op(KIND_SR, 4'd4, 4'd4);
    reg_op(KIND_SR, 4'd5, 4'd3);
    reg_op(KIND_AR, 4'd4, 4'd3);
    storage_op(KIND_AH, 4'd5, 4'd0, 12'd4);
    storage_op(KIND_SH, 4'd3, 4'd0, 12'd0);
    storage_op(KIND_AH, 4'd1, 4'd0, 12'd2);    // -32768 + -32768
    storage_op(KIND_CH, 4'd2, 4'd0, 12'd0);
    storage_op(KIND_CH, 4'd3, 4'd0, 12'd2);
    storage_op(KIND_CH, 4'd3, 4'd0, 12'd0);
    storage_op(KIND_STH, 4'd2, 4'd3, 12'hFFE); // top halfword of the store
    storage_op(KIND_LH, 4'd6, 4'd3, 12'hFFE);
    storage_op(KIND_LH, 4'd7, 4'd0, 12'd1);    // odd address
    storage_op(KIND_LH, 4'd8, 4'd0, 12'd2);
    storage_op(KIND_AH, 4'd9, 4'd8, 12'h010);  // negative base sum
    storage_op(KIND_LH, 4'd10, 4'd0, 12'd0);
    storage_op(KIND_STH, 4'd9, 4'd10, 12'hFFF); // sum wraps past the address width
    storage_op(KIND_LH, 4'd11, 4'd7, 12'hFFF);
    drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        sender_burst   = ($urandom_range(0, 3) == 0);
        receiver_burst = ($urandom_range(0, 3) == 0);
      end
      if (n % 400 == 399) drain();
      send_random();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (failures == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
